### rtl/dtrs_pkg.sv
package dtrs_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned AccW  = 64;
  localparam int unsigned WideW = 128;

  typedef enum logic [1:0] {
    KIND_GN    = 2'd0,
    KIND_SD    = 2'd1,
    KIND_BLEND = 2'd2
  } step_kind_e;

  typedef enum logic [1:0] {
    OP_SQRT = 2'd0,
    OP_DIV  = 2'd1
  } wide_op_e;

  typedef struct packed {
    logic            start;
    wide_op_e        op;
    logic [WideW-1:0] num;
    logic [AccW-1:0]  den;
  } wide_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [AccW-1:0] q_lo;
    logic            q_hi_nz;
  } wide_rsp_t;

endpackage

### rtl/dogleg_trust_region_step_core.sv
// powell dogleg step core
// input channel s_axis: one beat per element pair, tdata = {sd_element, gn_element}
// with gn_element in the low 32 bits; tuser carries the trust radius (31 bits),
// tlast marks the final pair. the radius is only used on the tlast beat.
// each input beat has an accept cycle, then one shared 32x32
// multiplier forms gn*gn, sd*sd and gn*sd in turn; pairs beyond VECTOR_LENGTH
// are dropped. on the tlast beat the core picks the gauss-newton,
// scaled steepest-descent or blended step and streams n result beats on m_axis:
// tdata = step element, tuser = {blend_factor, step_kind}, tlast on the last.
// the decision uses a shared bit-serial unit for square root and division, at most
// one root and one division per vector. each result beat then passes ram read,
// multiply and output, and the steepest-descent kind runs one division per element.
// s_axis_tready is low from the accept of a beat until the core is idle again.
// the last result beat may still wait in the output register while the next
// vector loads; m_axis holds its beat while m_axis_tready is low and the core waits.
// reset clears the sums, counter and sequencer; the element stores are not
// cleared, since only entries written in the current vector are read.
module dogleg_trust_region_step_core #(
  parameter int unsigned VECTOR_LENGTH = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // gn_element, sd_element
  input  logic [30:0] s_axis_tuser,  // trust_radius
  input  logic        s_axis_tlast,  // final_element
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // step_element
  output logic [33:0] m_axis_tuser,  // step_kind, blend_factor
  output logic        m_axis_tlast   // end_of_step
);

  localparam int unsigned AddrW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int unsigned CntW  = $clog2(VECTOR_LENGTH + 1);
  localparam int unsigned AccW  = dtrs_pkg::AccW;
  localparam int unsigned WideW = dtrs_pkg::WideW;
  localparam logic [31:0] BetaCap = 32'h7fff_ffff;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_M0    = 5'd1;
  localparam logic [4:0] S_M1    = 5'd2;
  localparam logic [4:0] S_M2    = 5'd3;
  localparam logic [4:0] S_DEC   = 5'd4;
  localparam logic [4:0] S_NORM  = 5'd5;
  localparam logic [4:0] S_BL0   = 5'd6;
  localparam logic [4:0] S_BL1   = 5'd7;
  localparam logic [4:0] S_BL2   = 5'd8;
  localparam logic [4:0] S_BL3   = 5'd9;
  localparam logic [4:0] S_BLSQ  = 5'd10;
  localparam logic [4:0] S_BLDIV = 5'd11;
  localparam logic [4:0] S_RD    = 5'd12;
  localparam logic [4:0] S_RDW   = 5'd13;
  localparam logic [4:0] S_EM0   = 5'd14;
  localparam logic [4:0] S_EM1   = 5'd15;
  localparam logic [4:0] S_EMDIV = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;
  localparam logic [4:0] S_WAIT  = 5'd18;

  logic [4:0] state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic fin_q, fin_d;
  logic store_q, store_d;
  logic [31:0] gn_q, gn_d, sd_q, sd_d;
  logic [30:0] rad_q, rad_d;
  logic [AccW-1:0] gsum_q, gsum_d, ssum_q, ssum_d, csum_q, csum_d;
  logic [AccW-1:0] r2_q, r2_d, norm_q, norm_d;
  logic [AccW-1:0] cmag_q, cmag_d, dq_q, dq_d, tq_q, tq_d, sq_q, sq_d;
  logic cneg_q, cneg_d;
  logic [WideW-1:0] acc_q, acc_d;
  logic [1:0] kind_q, kind_d;
  logic [31:0] beta_q, beta_d;
  logic [31:0] res_q, res_d;
  logic [31:0] outd_q, outd_d;
  logic [1:0] okind_q, okind_d;
  logic [31:0] obeta_q, obeta_d;
  logic outlast_q, outlast_d;
  logic oval_q, oval_d;
  logic [AccW-1:0] prod_q, prod_d;
  logic wsel_q, wsel_d;

  // shared multiplier, 64x64 split into 32x32 partial products over cycles
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = 64'(ma) * 64'(mb);

  dtrs_pkg::wide_req_t wreq;
  dtrs_pkg::wide_rsp_t wrsp;

  dtrs_wide_unit u_wide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (wreq),
    .rsp_o  (wrsp)
  );

  logic ram_we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0] gn_rd, sd_rd;

  dtrs_ram #(.Width(32), .Depth(VECTOR_LENGTH)) u_gn_ram (
    .clk_i (clk_i), .we_i (ram_we), .waddr_i (waddr), .wdata_i (gn_q),
    .raddr_i (raddr), .rdata_o (gn_rd)
  );

  dtrs_ram #(.Width(32), .Depth(VECTOR_LENGTH)) u_sd_ram (
    .clk_i (clk_i), .we_i (ram_we), .waddr_i (waddr), .wdata_i (sd_q),
    .raddr_i (raddr), .rdata_o (sd_rd)
  );

  assign waddr = count_q[AddrW-1:0];
  assign raddr = idx_q[AddrW-1:0];
  assign ram_we = (state_q == S_M0) && store_q;

  logic [31:0] gabs, sabs;
  assign gabs = gn_q[31] ? 32'(-gn_q) : gn_q;
  assign sabs = sd_q[31] ? 32'(-sd_q) : sd_q;

  logic signed [AccW-1:0] cq_w, dq_w, gs_diff;
  logic [AccW-1:0] fs_w;
  logic signed [32:0] diff33;
  logic signed [AccW-1:0] blend_w;

  always_comb begin
    state_d = state_q; count_d = count_q; idx_d = idx_q; fin_d = fin_q;
    store_d = store_q; gn_d = gn_q; sd_d = sd_q; rad_d = rad_q;
    gsum_d = gsum_q; ssum_d = ssum_q; csum_d = csum_q; r2_d = r2_q;
    norm_d = norm_q; cmag_d = cmag_q; dq_d = dq_q; tq_d = tq_q; sq_d = sq_q;
    cneg_d = cneg_q; acc_d = acc_q; kind_d = kind_q; beta_d = beta_q;
    res_d = res_q; outd_d = outd_q; okind_d = okind_q; obeta_d = obeta_q;
    outlast_d = outlast_q; oval_d = oval_q;
    prod_d = prod_q; wsel_d = wsel_q;
    ma = 32'd0; mb = 32'd0;
    wreq.start = 1'b0; wreq.op = dtrs_pkg::OP_SQRT; wreq.num = '0; wreq.den = '0;
    cq_w = '0; dq_w = '0; gs_diff = '0; fs_w = '0; diff33 = '0;
    blend_w = '0;
    if (oval_q && m_axis_tready) begin
      oval_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          gn_d = s_axis_tdata[31:0];
          sd_d = s_axis_tdata[63:32];
          rad_d = s_axis_tuser;
          fin_d = s_axis_tlast;
          store_d = (count_q < CntW'(VECTOR_LENGTH));
          state_d = S_M0;
        end
      end
      S_M0: begin
        ma = gabs; mb = gabs;
        if (store_q) begin
          gsum_d = gsum_q + (mp >> FRACTION_BITS);
        end
        state_d = S_M1;
      end
      S_M1: begin
        ma = sabs; mb = sabs;
        if (store_q) begin
          ssum_d = ssum_q + (mp >> FRACTION_BITS);
        end
        state_d = S_M2;
      end
      S_M2: begin
        ma = gabs; mb = sabs;
        if (store_q) begin
          if (gn_q[31] ^ sd_q[31]) begin
            fs_w = ~((mp - 64'd1) >> FRACTION_BITS);
            if (mp == 64'd0) fs_w = '0;
          end else begin
            fs_w = mp >> FRACTION_BITS;
          end
          csum_d = csum_q + fs_w;
          count_d = count_q + CntW'(1);
        end
        state_d = S_IDLE;
        if (fin_q) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        ma = {1'b0, rad_q}; mb = {1'b0, rad_q};
        r2_d = mp >> FRACTION_BITS;
        if (gsum_q < AccW'(mp >> FRACTION_BITS)) begin
          kind_d = dtrs_pkg::KIND_GN;
          beta_d = 32'(64'd2 << FRACTION_BITS);
          idx_d = '0; state_d = S_RD;
        end else if (ssum_q > AccW'(mp >> FRACTION_BITS)) begin
          kind_d = dtrs_pkg::KIND_SD;
          beta_d = 32'(-(64'd1 << FRACTION_BITS));
          wreq.start = 1'b1; wreq.op = dtrs_pkg::OP_SQRT;
          wreq.num = WideW'(ssum_q) << FRACTION_BITS;
          state_d = S_NORM;
        end else begin
          kind_d = dtrs_pkg::KIND_BLEND;
          cq_w = csum_q - ssum_q;
          dq_w = gsum_q - (csum_q << 1) + ssum_q;
          cneg_d = cq_w[AccW-1];
          cmag_d = cq_w[AccW-1] ? AccW'(-cq_w) : cq_w;
          dq_d = dq_w[AccW-1] ? '0 : dq_w;
          tq_d = AccW'(mp >> FRACTION_BITS) - ssum_q;
          acc_d = '0; wsel_d = 1'b0;
          state_d = S_BL0;
        end
      end
      S_NORM: begin
        if (wrsp.done) begin
          norm_d = wrsp.q_lo; idx_d = '0; state_d = S_RD;
        end
      end
      // cmag^2 + dq*tq by 32x32 partial products, two operand pairs
      S_BL0: begin
        ma = wsel_q ? dq_q[31:0] : cmag_q[31:0];
        mb = wsel_q ? tq_q[31:0] : cmag_q[31:0];
        acc_d = acc_q + WideW'(mp);
        state_d = S_BL1;
      end
      S_BL1: begin
        ma = wsel_q ? dq_q[63:32] : cmag_q[63:32];
        mb = wsel_q ? tq_q[31:0] : cmag_q[31:0];
        acc_d = acc_q + (WideW'(mp) << 32);
        state_d = S_BL2;
      end
      S_BL2: begin
        ma = wsel_q ? dq_q[31:0] : cmag_q[31:0];
        mb = wsel_q ? tq_q[63:32] : cmag_q[63:32];
        acc_d = acc_q + (WideW'(mp) << 32);
        state_d = S_BL3;
      end
      S_BL3: begin
        ma = wsel_q ? dq_q[63:32] : cmag_q[63:32];
        mb = wsel_q ? tq_q[63:32] : cmag_q[63:32];
        acc_d = acc_q + (WideW'(mp) << 64);
        if (!wsel_q) begin
          wsel_d = 1'b1; state_d = S_BL0;
        end else begin
          wreq.start = 1'b1; wreq.op = dtrs_pkg::OP_SQRT;
          wreq.num = acc_q + (WideW'(mp) << 64);
          state_d = S_BLSQ;
        end
      end
      S_BLSQ: begin
        if (wrsp.done) begin
          sq_d = wrsp.q_lo;
          if (cneg_q) begin
            if (dq_q == '0) begin
              beta_d = '0; idx_d = '0; state_d = S_RD;
            end else begin
              wreq.start = 1'b1; wreq.op = dtrs_pkg::OP_DIV;
              wreq.num = WideW'(wrsp.q_lo + cmag_q) << FRACTION_BITS;
              wreq.den = dq_q; state_d = S_BLDIV;
            end
          end else if ((cmag_q + wrsp.q_lo) == '0) begin
            beta_d = '0; idx_d = '0; state_d = S_RD;
          end else begin
            wreq.start = 1'b1; wreq.op = dtrs_pkg::OP_DIV;
            wreq.num = WideW'(tq_q) << FRACTION_BITS;
            wreq.den = cmag_q + wrsp.q_lo; state_d = S_BLDIV;
          end
        end
      end
      S_BLDIV: begin
        if (wrsp.done) begin
          if (wrsp.q_hi_nz || wrsp.q_lo > AccW'(BetaCap)) beta_d = BetaCap;
          else beta_d = wrsp.q_lo[31:0];
          idx_d = '0; state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_RDW;
      end
      S_RDW: begin
        gn_d = gn_rd; sd_d = sd_rd;
        state_d = S_EM0;
      end
      S_EM0: begin
        diff33 = $signed({gn_q[31], gn_q}) - $signed({sd_q[31], sd_q});
        if (kind_q == dtrs_pkg::KIND_SD) begin
          ma = sabs; mb = {1'b0, rad_q};
        end else begin
          ma = diff33[32] ? 32'(-diff33) : diff33[31:0];
          mb = beta_q;
        end
        prod_d = mp;
        wsel_d = diff33[32];
        state_d = S_EM1;
      end
      S_EM1: begin
        if (kind_q == dtrs_pkg::KIND_GN) begin
          res_d = gn_q; state_d = S_OUT;
        end else if (kind_q == dtrs_pkg::KIND_SD) begin
          wreq.start = 1'b1; wreq.op = dtrs_pkg::OP_DIV;
          wreq.num = WideW'(prod_q); wreq.den = norm_q;
          state_d = S_EMDIV;
        end else begin
          if (!wsel_q) begin
            blend_w = $signed(AccW'(prod_q >> FRACTION_BITS));
          end else if (prod_q == '0) begin
            blend_w = '0;
          end else begin
            blend_w = $signed(~((prod_q - 64'd1) >> FRACTION_BITS));
          end
          gs_diff = $signed({{32{sd_q[31]}}, sd_q}) + blend_w;
          if (gs_diff > 64'sd2147483647) res_d = 32'h7fff_ffff;
          else if (gs_diff < -64'sd2147483648) res_d = 32'h8000_0000;
          else res_d = gs_diff[31:0];
          state_d = S_OUT;
        end
      end
      S_EMDIV: begin
        if (wrsp.done) begin
          if (norm_q == '0) begin
            res_d = '0;
          end else begin
            cq_w = sd_q[31] ? AccW'(-wrsp.q_lo) : wrsp.q_lo;
            if (cq_w > 64'sd2147483647) res_d = 32'h7fff_ffff;
            else if (cq_w < -64'sd2147483648) res_d = 32'h8000_0000;
            else res_d = cq_w[31:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!oval_q || m_axis_tready) begin
          oval_d = 1'b1;
          outd_d = res_q;
          okind_d = kind_q;
          obeta_d = beta_q;
          outlast_d = (idx_q + CntW'(1) == count_q);
          idx_d = idx_q + CntW'(1);
          if (idx_q + CntW'(1) == count_q) begin
            state_d = S_WAIT;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_WAIT: begin
        gsum_d = '0; ssum_d = '0; csum_d = '0; count_d = '0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q <= '0;
      gsum_q <= '0;
      ssum_q <= '0;
      csum_q <= '0;
      oval_q <= 1'b0;
      fin_q <= 1'b0;
      store_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q <= idx_d;
      gsum_q <= gsum_d;
      ssum_q <= ssum_d;
      csum_q <= csum_d;
      oval_q <= oval_d;
      fin_q <= fin_d;
      store_q <= store_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gn_q <= gn_d; sd_q <= sd_d; rad_q <= rad_d; r2_q <= r2_d; norm_q <= norm_d;
    cmag_q <= cmag_d; dq_q <= dq_d; tq_q <= tq_d; sq_q <= sq_d; cneg_q <= cneg_d;
    acc_q <= acc_d; kind_q <= kind_d; beta_q <= beta_d; res_q <= res_d;
    outd_q <= outd_d; okind_q <= okind_d; obeta_q <= obeta_d;
    outlast_q <= outlast_d; prod_q <= prod_d; wsel_q <= wsel_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = outd_q;
  assign m_axis_tuser  = {obeta_q, okind_q};
  assign m_axis_tlast  = outlast_q;

endmodule

### rtl/dtrs_ram.sv
module dtrs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                   wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                   rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/dtrs_wide_unit.sv
module dtrs_wide_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtrs_pkg::wide_req_t req_i,
  output dtrs_pkg::wide_rsp_t rsp_o
);

  localparam int unsigned WideW = dtrs_pkg::WideW;
  localparam int unsigned AccW  = dtrs_pkg::AccW;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [6:0]      cnt_q, cnt_d;
  dtrs_pkg::wide_op_e op_q, op_d;
  logic [WideW-1:0] num_q, num_d;
  logic [AccW-1:0]  den_q, den_d;
  logic [AccW:0]    rem_q, rem_d;
  logic [WideW-1:0] quo_q, quo_d;
  logic [WideW+1:0] srem_q, srem_d;
  logic [AccW-1:0]  root_q, root_d;

  logic [AccW:0]    rem_sh;
  logic [WideW+1:0] srem_sh;
  logic [WideW+1:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    srem_d = srem_q;
    root_d = root_q;
    rem_sh  = {rem_q[AccW-1:0], num_q[WideW-1]};
    srem_sh = {srem_q[WideW-1:0], num_q[WideW-1:WideW-2]};
    trial   = {(WideW-AccW)'(0), root_q, 2'b01};
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
      srem_d = '0;
      root_d = '0;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (op_q == dtrs_pkg::OP_DIV) begin
        num_d = {num_q[WideW-2:0], 1'b0};
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = rem_sh - {1'b0, den_q};
          quo_d = {quo_q[WideW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[WideW-2:0], 1'b0};
        end
        if (cnt_q == 7'd127) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        num_d = {num_q[WideW-3:0], 2'b00};
        if (srem_sh >= trial) begin
          srem_d = srem_sh - trial;
          root_d = {root_q[AccW-2:0], 1'b1};
        end else begin
          srem_d = srem_sh;
          root_d = {root_q[AccW-2:0], 1'b0};
        end
        if (cnt_q == 7'd63) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
      cnt_d = cnt_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= dtrs_pkg::OP_SQRT;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  always_comb begin
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    if (op_q == dtrs_pkg::OP_DIV) begin
      rsp_o.q_lo    = quo_q[AccW-1:0];
      rsp_o.q_hi_nz = |quo_q[WideW-1:AccW];
    end else begin
      rsp_o.q_lo    = root_q;
      rsp_o.q_hi_nz = 1'b0;
    end
  end

endmodule

### rtl/dtrs_checker.sv
module dtrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [33:0] m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed under stall");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1:0] == dtrs_pkg::KIND_GN ||
                       m_axis_tuser[1:0] == dtrs_pkg::KIND_SD ||
                       m_axis_tuser[1:0] == dtrs_pkg::KIND_BLEND))
    else $error("bad step kind");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a beat");

  a_gn_beta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == dtrs_pkg::KIND_GN |->
      m_axis_tuser[33:2] == 32'h0002_0000)
    else $error("gauss-newton beta wrong");

  a_sd_beta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == dtrs_pkg::KIND_SD |->
      m_axis_tuser[33:2] == 32'hffff_0000)
    else $error("steepest-descent beta wrong");

endmodule

bind dogleg_trust_region_step_core dtrs_checker u_dtrs_checker (
  .clk_i (clk_i), .rst_ni (rst_ni),
  .s_axis_tvalid (s_axis_tvalid), .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid), .m_axis_tready (m_axis_tready),
  .m_axis_tdata (m_axis_tdata), .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
